### rtl/sli_pkg.sv
// Shared types and codes for the sorted list insert/delete block.
package sli_pkg;

   localparam int DataW = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_DELETED   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // Command broadcast from the control logic to every cell.
   typedef struct packed {
      logic                    ins_go;
      logic                    del_go;
      logic signed [DataW-1:0] value;
   } sli_cmd_type;

endpackage

### rtl/sli_if.sv
// Request and response channel interfaces of the sorted list block.
interface sli_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

interface sli_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [4:0]         entry_count;
   logic signed [31:0] smallest_value;

   modport source (output valid, output status, output entry_count, output smallest_value,
                   input ready);
   modport sink (input valid, input status, input entry_count, input smallest_value,
                 output ready);
endinterface

### rtl/sli_cell.sv
// One storage cell of the sorted list: holds one entry and shifts with its neighbors.
module sli_cell
   import sli_pkg::*;
(
   input  logic                    clock,
   input  sli_cmd_type             cmd,
   input  logic                    valid,
   input  logic                    lower_cond,
   input  logic signed [DataW-1:0] lower_entry,
   input  logic signed [DataW-1:0] upper_entry,
   output logic                    cond_out,
   output logic                    eq_out,
   output logic signed [DataW-1:0] entry_out,
   output logic signed [DataW-1:0] entry_next_out
);

   logic signed [DataW-1:0] entry_ff;
   logic signed [DataW-1:0] entry_in;
   logic                    ge;

   // The entry is at or above the command value; an empty cell counts as an insert point.
   assign ge       = valid && (entry_ff >= cmd.value);
   assign cond_out = !valid || ge;
   assign eq_out   = valid && (entry_ff == cmd.value);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_go) begin
         if (lower_cond) begin
            entry_in = lower_entry;
         end else if (cond_out) begin
            entry_in = cmd.value;
         end
      end else if (cmd.del_go && ge) begin
         entry_in = upper_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out      = entry_ff;
   assign entry_next_out = entry_in;

endmodule

### rtl/sorted_list_insert_delete.sv
// Top level of the sorted list block: a row of compare-and-shift cells and the response register.
// The block keeps up to CAPACITY signed 32-bit values in ascending order, one value per cell.
// Every cell compares its entry with the request value in parallel, and all cells shift up
// (insert) or down (delete) in the same clock edge; a new request is accepted every cycle
// as long as the response beat is taken. The response is registered; it carries the status,
// the entry count after the operation (low five bits) and the smallest stored value, zero
// when the list is empty. An insert into a full list is dropped and reported as full; a
// delete with no matching value leaves the list unchanged.
module sorted_list_insert_delete
   import sli_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   sli_req_if.sink   req_ch,
   sli_rsp_if.source rsp_ch
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [1:0]              rsp_status_in;
   logic [4:0]              rsp_count_ff;
   logic signed [DataW-1:0] rsp_small_ff;
   logic signed [DataW-1:0] rsp_small_in;

   logic                    accept;
   logic                    full;
   logic                    found;
   sli_cmd_type             cmd;

   logic [CAPACITY-1:0]     cell_valid;
   logic [CAPACITY-1:0]     cell_cond;
   logic [CAPACITY-1:0]     cell_eq;
   logic signed [DataW-1:0] cell_entry [CAPACITY];
   logic signed [DataW-1:0] cell_next  [CAPACITY];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CntW'(CAPACITY));
   assign found        = |cell_eq;

   assign cmd.ins_go = accept && (req_ch.opcode == OP_INSERT) && !full;
   assign cmd.del_go = accept && (req_ch.opcode == OP_DELETE) && found;
   assign cmd.value  = req_ch.value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    lower_cond;
      logic signed [DataW-1:0] lower_entry;
      logic signed [DataW-1:0] upper_entry;

      assign cell_valid[i] = (count_ff > CntW'(i));

      if (i == 0) begin : g_first
         assign lower_cond  = 1'b0;
         assign lower_entry = '0;
      end else begin : g_inner
         assign lower_cond  = cell_cond[i-1];
         assign lower_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign upper_entry = cell_entry[i];
      end else begin : g_below
         assign upper_entry = cell_entry[i+1];
      end

      sli_cell u_cell (
         .clock          (clock),
         .cmd            (cmd),
         .valid          (cell_valid[i]),
         .lower_cond     (lower_cond),
         .lower_entry    (lower_entry),
         .upper_entry    (upper_entry),
         .cond_out       (cell_cond[i]),
         .eq_out         (cell_eq[i]),
         .entry_out      (cell_entry[i]),
         .entry_next_out (cell_next[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_NOT_FOUND;
      if (req_ch.opcode == OP_INSERT) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_INSERTED;
            count_in      = count_ff + CntW'(1);
         end
      end else if (found) begin
         rsp_status_in = ST_DELETED;
         count_in      = count_ff - CntW'(1);
      end
      rsp_small_in = (count_in == '0) ? '0 : cell_next[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= 5'(count_in);
         rsp_small_ff  <= rsp_small_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.entry_count    = rsp_count_ff;
   assign rsp_ch.smallest_value = rsp_small_ff;

   // The entry count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("entry count above capacity");

   // An accepted insert into a table with room grows the count by one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.opcode == OP_INSERT && !full) |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("insert did not grow the count");

   // Every accepted request beat yields a response beat in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("no response after accepted request");

   // A full report only comes with an unchanged full count.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_status_in == ST_FULL) |=> count_ff == CntW'(CAPACITY))
      else $error("full status with room in the table");

endmodule
